// ----- src/stla_pkg.sv -----
package stla_pkg;

    localparam int DEF_SESSIONS  = 1024;
    localparam int DEF_BUCKETS   = 1024;
    localparam int DEF_KEY_BYTES = 32;

    localparam int KEY_W   = 256;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 10;
    localparam int STAT_W  = 2;
    localparam int HW_MASK = 'h0F;

    localparam logic [OP_W-1:0] OP_NEW  = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTUSE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [63:0]      key_word_0;
        logic [63:0]      key_word_1;
        logic [63:0]      key_word_2;
        logic [63:0]      key_word_3;
        logic [IDX_W-1:0] session_index;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  result_index;
    } t_out;

endpackage

// ----- src/stla_hash.sv -----
module stla_hash #(
    parameter int BUCKETS = stla_pkg::DEF_BUCKETS,
    parameter int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [stla_pkg::KEY_W-1:0] i_key,
    output logic                       o_done,
    output logic [BKT_W-1:0]           o_bucket
);
    // fixed-point reciprocal; the quotient estimate is low by at most one
    localparam logic [31:0] RECIP = 32'((64'd1 << 31) / 64'(BUCKETS));

    logic [31:0] r_acc;
    logic [31:0] r_q;
    logic [31:0] r_qb;
    logic [31:0] r_rem;
    logic        r_s1, r_s2, r_s3, r_done;
    logic [31:0] w_hash;
    logic [63:0] w_prod;
    logic [31:0] w_diff;

    // xor of shifted half-words
    always_comb begin
        w_hash = '0;
        for (int i = 0; i < 16; i++) begin
            w_hash = w_hash ^ (32'(i_key[16*i +: 16]) << (i & stla_pkg::HW_MASK));
        end
    end

    // remainder by BUCKETS: estimate, multiply back, one correction
    assign w_prod = 64'(r_acc) * 64'(RECIP);
    assign w_diff = r_acc - r_qb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_s3   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start;
            r_s2   <= r_s1;
            r_s3   <= r_s2;
            r_done <= r_s3;
        end
        if (i_start) begin
            r_acc <= w_hash;
        end
        r_q   <= 32'(w_prod >> 31);
        r_qb  <= 32'(64'(r_q) * 64'(BUCKETS));
        r_rem <= (w_diff >= 32'(BUCKETS)) ? (w_diff - 32'(BUCKETS)) : w_diff;
    end

    assign o_done   = r_done;
    assign o_bucket = BKT_W'(r_rem);

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < 32'(BUCKETS))) else $error("remainder out of range");

endmodule

// ----- src/session_table_alloc_lookup_unit.sv -----
// Channel  Dir  Handshake         Payload
// input    in   i_valid/o_stall   i_data (stla_pkg::t_in)
// result   out  o_valid/i_stall   o_data (stla_pkg::t_out)
//
// One item at a time. A new takes an extra write when its bucket was not
// empty, a find one step per chain entry visited, a free an extra write when
// the free list was not empty; table full and unknown operation go straight
// to the result. Waits on the hash unit and on the session memory set how
// long each item takes; the block returns to idle as the result is loaded.
// After reset a clearing pass over max(SESSIONS, BUCKETS) entries runs before
// the first item is taken. The result sits in an output register; a stalled
// result holds the block only once the next item is done.
module session_table_alloc_lookup_unit #(
    parameter int SESSIONS  = stla_pkg::DEF_SESSIONS,
    parameter int BUCKETS   = stla_pkg::DEF_BUCKETS,
    parameter int KEY_BYTES = stla_pkg::DEF_KEY_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  stla_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output stla_pkg::t_out  o_data
);
    localparam int KW    = stla_pkg::KEY_W;
    localparam int ID_W  = $clog2(SESSIONS + 1);
    localparam int SA_W  = $clog2(SESSIONS);
    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CLR_N = (SESSIONS > BUCKETS) ? SESSIONS : BUCKETS;
    localparam int CW    = $clog2(CLR_N);
    localparam logic [ID_W-1:0] NULL_ID = ID_W'(SESSIONS);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_HASH = 5'd2;
    localparam logic [4:0] S_NWR  = 5'd3;
    localparam logic [4:0] S_NPW  = 5'd4;
    localparam logic [4:0] S_FHW  = 5'd5;
    localparam logic [4:0] S_FCMP = 5'd6;
    localparam logic [4:0] S_RCHK = 5'd7;
    localparam logic [4:0] S_RP   = 5'd8;
    localparam logic [4:0] S_RN   = 5'd9;
    localparam logic [4:0] S_RS   = 5'd10;
    localparam logic [4:0] S_RT   = 5'd11;
    localparam logic [4:0] S_DONE = 5'd12;

    // session memory, one entry per session, written by field; bucket heads, one per bucket
    logic [KW-1:0]   m_key  [SESSIONS];
    logic            m_use  [SESSIONS];
    logic [ID_W-1:0] m_link [SESSIONS];
    logic [ID_W-1:0] m_next [SESSIONS];
    logic [ID_W-1:0] m_prev [SESSIONS];
    logic [ID_W-1:0] m_head [BUCKETS];

    logic [KW-1:0]   rd_key;
    logic            rd_use;
    logic [ID_W-1:0] rd_link, rd_next, rd_prev, rd_head;

    logic [SA_W-1:0]  w_raddr, w_waddr;
    logic [BKT_W-1:0] w_braddr, w_bwaddr;
    logic             we_key, we_use, we_link, we_next, we_prev, we_head;
    logic [KW-1:0]    wd_key;
    logic             wd_use;
    logic [ID_W-1:0]  wd_link, wd_next, wd_prev, wd_head;

    logic [4:0]        r_state, n_state;
    logic [CW-1:0]     r_clr, n_clr;
    logic [1:0]        r_op, n_op;
    logic [KW-1:0]     r_key, n_key;
    logic [ID_W-1:0]   r_s, n_s, r_p, n_p, r_n, n_n, r_aux, n_aux;
    logic [ID_W-1:0]   r_fhead, n_fhead, r_ftail, n_ftail;
    logic [BKT_W-1:0]  r_bkt, n_bkt;
    logic [1:0]        r_stat, n_stat;
    logic [ID_W-1:0]   r_res, n_res;
    logic              r_hstart, n_hstart;
    logic              r_ovalid, n_ovalid;
    stla_pkg::t_out    r_out, n_out;

    logic              w_hdone;
    logic [BKT_W-1:0]  w_hbkt;
    logic [KW-1:0]     w_canon;
    logic              w_acc;

    stla_hash #(.BUCKETS(BUCKETS), .BKT_W(BKT_W)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_hstart),
        .i_key    (r_key),
        .o_done   (w_hdone),
        .o_bucket (w_hbkt)
    );

    // key ends at its first zero byte or at KEY_BYTES
    always_comb begin
        logic       ended;
        logic [7:0] by;
        logic [KW-1:0] raw;
        raw   = {i_data.key_word_3, i_data.key_word_2, i_data.key_word_1, i_data.key_word_0};
        ended = 1'b0;
        w_canon = '0;
        for (int b = 0; b < 32; b++) begin
            by = raw[8*b +: 8];
            if (b >= KEY_BYTES || ended) begin
                by = 8'd0;
            end
            if (by == 8'd0) begin
                ended = 1'b1;
            end
            w_canon[8*b +: 8] = by;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign w_acc   = i_valid && !o_stall;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_op     = r_op;
        n_key    = r_key;
        n_s      = r_s;
        n_p      = r_p;
        n_n      = r_n;
        n_aux    = r_aux;
        n_fhead  = r_fhead;
        n_ftail  = r_ftail;
        n_bkt    = r_bkt;
        n_stat   = r_stat;
        n_res    = r_res;
        n_hstart = 1'b0;
        n_ovalid = r_ovalid && i_stall;
        n_out    = r_out;
        w_raddr  = SA_W'(r_s);
        w_braddr = r_bkt;
        w_waddr  = SA_W'(r_s);
        w_bwaddr = r_bkt;
        we_key = 1'b0; we_use = 1'b0; we_link = 1'b0;
        we_next = 1'b0; we_prev = 1'b0; we_head = 1'b0;
        wd_key = '0; wd_use = 1'b0; wd_link = NULL_ID;
        wd_next = NULL_ID; wd_prev = NULL_ID; wd_head = NULL_ID;

        case (r_state)
            S_CLR: begin
                w_waddr  = SA_W'(r_clr);
                w_bwaddr = BKT_W'(r_clr);
                if (32'(r_clr) < SESSIONS) begin
                    we_use  = 1'b1;
                    we_link = 1'b1;
                    we_next = 1'b1;
                    we_prev = 1'b1;
                    wd_link = (32'(r_clr) == SESSIONS - 1) ? NULL_ID
                                                         : ID_W'(r_clr) + ID_W'(1);
                end
                we_head = (32'(r_clr) < BUCKETS);
                n_clr   = r_clr + CW'(1);
                if (32'(r_clr) == CLR_N - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_op  = i_data.operation;
                    n_key = w_canon;
                    n_res = '0;
                    n_s   = ID_W'(i_data.session_index);
                    case (i_data.operation)
                        stla_pkg::OP_NEW: begin
                            if (r_fhead == NULL_ID) begin
                                n_stat  = stla_pkg::ST_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_s      = r_fhead;
                                n_hstart = 1'b1;
                                n_state  = S_HASH;
                            end
                        end
                        stla_pkg::OP_FIND: begin
                            n_hstart = 1'b1;
                            n_state  = S_HASH;
                        end
                        stla_pkg::OP_FREE: begin
                            if (32'(i_data.session_index) >= SESSIONS) begin
                                n_stat  = stla_pkg::ST_NOTUSE;
                                n_state = S_DONE;
                            end else begin
                                w_raddr = SA_W'(i_data.session_index);
                                n_state = S_RCHK;
                            end
                        end
                        default: begin
                            n_stat  = stla_pkg::ST_NFOUND;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (w_hdone) begin
                    n_bkt    = w_hbkt;
                    w_braddr = w_hbkt;
                    w_raddr  = SA_W'(r_s);
                    case (r_op)
                        stla_pkg::OP_NEW:  n_state = S_NWR;
                        stla_pkg::OP_FIND: n_state = S_FHW;
                        default:           n_state = S_RP;
                    endcase
                end
            end
            S_NWR: begin
                we_key  = 1'b1; wd_key  = r_key;
                we_use  = 1'b1; wd_use  = 1'b1;
                we_link = 1'b1;
                we_next = 1'b1; wd_next = rd_head;
                we_prev = 1'b1;
                we_head = 1'b1; wd_head = r_s;
                n_fhead = rd_link;
                if (rd_link == NULL_ID) begin
                    n_ftail = NULL_ID;
                end
                n_stat = stla_pkg::ST_OK;
                n_res  = r_s;
                n_aux  = rd_head;
                n_state = (rd_head != NULL_ID) ? S_NPW : S_DONE;
            end
            S_NPW: begin
                w_waddr = SA_W'(r_aux);
                we_prev = 1'b1;
                wd_prev = r_s;
                n_state = S_DONE;
            end
            S_FHW: begin
                n_stat = stla_pkg::ST_NFOUND;
                if (rd_head == NULL_ID) begin
                    n_state = S_DONE;
                end else begin
                    n_aux   = rd_head;
                    w_raddr = SA_W'(rd_head);
                    n_state = S_FCMP;
                end
            end
            S_FCMP: begin
                if (rd_key == r_key) begin
                    n_stat  = stla_pkg::ST_OK;
                    n_res   = r_aux;
                    n_state = S_DONE;
                end else if (rd_next == NULL_ID) begin
                    n_state = S_DONE;
                end else begin
                    n_aux   = rd_next;
                    w_raddr = SA_W'(rd_next);
                end
            end
            S_RCHK: begin
                if (!rd_use) begin
                    n_stat  = stla_pkg::ST_NOTUSE;
                    n_state = S_DONE;
                end else begin
                    n_p      = rd_prev;
                    n_n      = rd_next;
                    n_key    = rd_key;
                    n_hstart = 1'b1;
                    n_state  = S_HASH;
                end
            end
            S_RP: begin
                if (r_p != NULL_ID) begin
                    w_waddr = SA_W'(r_p);
                    we_next = 1'b1;
                    wd_next = r_n;
                end else begin
                    we_head = 1'b1;
                    wd_head = r_n;
                end
                n_state = S_RN;
            end
            S_RN: begin
                if (r_n != NULL_ID) begin
                    w_waddr = SA_W'(r_n);
                    we_prev = 1'b1;
                    wd_prev = r_p;
                end
                n_state = S_RS;
            end
            S_RS: begin
                we_key = 1'b1; we_use = 1'b1; we_link = 1'b1;
                we_next = 1'b1; we_prev = 1'b1;
                n_stat  = stla_pkg::ST_OK;
                n_ftail = r_s;
                if (r_ftail == NULL_ID) begin
                    n_fhead = r_s;
                    n_state = S_DONE;
                end else begin
                    n_aux   = r_ftail;
                    n_state = S_RT;
                end
            end
            S_RT: begin
                w_waddr = SA_W'(r_aux);
                we_link = 1'b1;
                wd_link = r_s;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid           = 1'b1;
                    n_out.status       = r_stat;
                    n_out.result_index = r_res[stla_pkg::IDX_W-1:0];
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we_key)  m_key[w_waddr]  <= wd_key;
        if (we_use)  m_use[w_waddr]  <= wd_use;
        if (we_link) m_link[w_waddr] <= wd_link;
        if (we_next) m_next[w_waddr] <= wd_next;
        if (we_prev) m_prev[w_waddr] <= wd_prev;
        if (we_head) m_head[w_bwaddr] <= wd_head;
        rd_key  <= m_key[w_raddr];
        rd_use  <= m_use[w_raddr];
        rd_link <= m_link[w_raddr];
        rd_next <= m_next[w_raddr];
        rd_prev <= m_prev[w_raddr];
        rd_head <= m_head[w_braddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_fhead  <= '0;
            r_ftail  <= ID_W'(SESSIONS - 1);
            r_hstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_fhead  <= n_fhead;
            r_ftail  <= n_ftail;
            r_hstart <= n_hstart;
            r_ovalid <= n_ovalid;
        end
        r_op   <= n_op;
        r_key  <= n_key;
        r_s    <= n_s;
        r_p    <= n_p;
        r_n    <= n_n;
        r_aux  <= n_aux;
        r_bkt  <= n_bkt;
        r_stat <= n_stat;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    a_free_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_fhead == NULL_ID) == (r_ftail == NULL_ID)))
        else $error("free list head and tail disagree");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

    a_hash_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hdone |-> (r_state == S_HASH))
        else $error("hash finished while not waited for");

endmodule
